@@ sv/brlt_pkg.sv @@
// Shared types and codes for the byte-range lock table.
package brlt_pkg;

    localparam int RANGE_BITS  = 63;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Request kind codes as they arrive on the port
    localparam logic [1:0] KIND_READ    = 2'd0;
    localparam logic [1:0] KIND_WRITE   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_CONFLICT = 2'd1,
        ST_NO_FREE  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_WRITE
    } back_state_t;

    typedef struct packed {
        op_t                   op;
        logic [RANGE_BITS-1:0] start;
        logic [RANGE_BITS-1:0] len;
        logic [RANGE_BITS:0]   range_end;
        logic                  zero_len;
    } cmd_t;

endpackage

@@ sv/byte_range_lock_table.sv @@
// Top level of the byte-range lock table: front end, command queue and slot engine.
//
// An item is taken when start is high and busy is low; up to two items wait in a
// queue while the engine works, and busy is high only while that queue is full.
// Each item gives one result: status is valid for the single cycle in which done
// is high, and the receiver must take it then. The engine reads the slot table
// through the one read port of its slot RAM, one slot a cycle. A lock request
// scans every slot unless a conflict ends the scan early, then writes a free slot
// if it found one; a release scans every slot; an item with the unused kind code
// is answered from the idle state with no scan. The engine takes each item off
// the queue in its idle state.
module byte_range_lock_table import brlt_pkg::*; #(
    parameter int SLOT_COUNT = 8,
    parameter int OWNER_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [OWNER_BITS-1:0] owner_id,
    input  logic [1:0]            request_kind,
    input  logic [RANGE_BITS-1:0] range_start,
    input  logic [RANGE_BITS-1:0] range_length,
    output logic                  done,
    output logic [1:0]            status
);

    logic                  q_valid;
    logic                  q_pop;
    cmd_t                  q_cmd;
    logic [OWNER_BITS-1:0] q_owner;

    brlt_front #(
        .OWNER_BITS (OWNER_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .owner_id     (owner_id),
        .request_kind (request_kind),
        .range_start  (range_start),
        .range_length (range_length),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_cmd        (q_cmd),
        .q_owner      (q_owner)
    );

    brlt_back #(
        .SLOT_COUNT (SLOT_COUNT),
        .OWNER_BITS (OWNER_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_cmd   (q_cmd),
        .q_owner (q_owner),
        .done    (done),
        .status  (status)
    );

endmodule

@@ sv/brlt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module brlt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

@@ sv/brlt_front.sv @@
// Front end: accepts items, decodes the kind, forms the range end and queues them.
module brlt_front import brlt_pkg::*; #(
    parameter int OWNER_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [OWNER_BITS-1:0] owner_id,
    input  logic [1:0]            request_kind,
    input  logic [RANGE_BITS-1:0] range_start,
    input  logic [RANGE_BITS-1:0] range_length,
    output logic                  q_valid,
    input  logic                  q_pop,
    output cmd_t                  q_cmd,
    output logic [OWNER_BITS-1:0] q_owner
);

    cmd_t                  cmd_in;
    op_t                   op_in;
    logic                  push;
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]     count_reg, count_next;
    cmd_t                  q_cmd_reg   [QUEUE_DEPTH];
    logic [OWNER_BITS-1:0] q_owner_reg [QUEUE_DEPTH];

    always_comb
    begin
        unique case (request_kind)
            KIND_READ:    op_in = OP_READ;
            KIND_WRITE:   op_in = OP_WRITE;
            KIND_RELEASE: op_in = OP_RELEASE;
            KIND_UNUSED:  op_in = OP_NONE;
            default:      op_in = OP_NONE;
        endcase
    end

    always_comb
    begin
        cmd_in.op        = op_in;
        cmd_in.start     = range_start;
        cmd_in.len       = range_length;
        cmd_in.range_end = {1'b0, range_start} + {1'b0, range_length};
        cmd_in.zero_len  = (range_length == '0);
    end

    assign busy    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign q_cmd   = q_cmd_reg[rd_ptr_reg];
    assign q_owner = q_owner_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_cmd_reg[wr_ptr_reg]   <= cmd_in;
            q_owner_reg[wr_ptr_reg] <= owner_id;
        end
    end

endmodule

@@ sv/brlt_back.sv @@
// Back end: scans the slot table one slot a cycle, then grants, refuses or releases.
module brlt_back import brlt_pkg::*; #(
    parameter int SLOT_COUNT = 8,
    parameter int OWNER_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  cmd_t                  q_cmd,
    input  logic [OWNER_BITS-1:0] q_owner,
    output logic                  done,
    output logic [1:0]            status
);

    localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int WORD_W = OWNER_BITS + 1 + 2 * RANGE_BITS;
    localparam int WR_BIT = 2 * RANGE_BITS;

    back_state_t           state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [OWNER_BITS-1:0] who_reg, who_next;
    logic [CNT_W-1:0]      issue_reg, issue_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic [SLOT_COUNT-1:0] valid_reg, valid_next;
    logic                  done_reg, done_next;
    status_t               status_reg, status_next;

    logic                  rd_en, wr_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [WORD_W-1:0]     rd_data, wr_data;

    logic [OWNER_BITS-1:0] slot_owner;
    logic                  slot_is_write;
    logic [RANGE_BITS-1:0] slot_start, slot_length;
    logic [RANGE_BITS:0]   slot_end;
    logic                  is_lock, is_release;
    logic                  pend_live, pend_other, clash, conflict, last_check, free_here;

    brlt_ram #(
        .WIDTH  (WORD_W),
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (IDX_W)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (free_idx_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign slot_owner    = rd_data[WORD_W-1 -: OWNER_BITS];
    assign slot_is_write = rd_data[WR_BIT];
    assign slot_start    = rd_data[WR_BIT-1 -: RANGE_BITS];
    assign slot_length   = rd_data[RANGE_BITS-1:0];
    assign slot_end      = {1'b0, slot_start} + {1'b0, slot_length};
    assign wr_data       = {who_reg, (cmd_reg.op == OP_WRITE), cmd_reg.start, cmd_reg.len};

    assign is_lock    = (cmd_reg.op == OP_READ) || (cmd_reg.op == OP_WRITE);
    assign is_release = (cmd_reg.op == OP_RELEASE);

    // Two reads never clash; otherwise a zero length clashes with anything
    assign clash = ((cmd_reg.op == OP_WRITE) || slot_is_write)
                   && (cmd_reg.zero_len || (slot_length == '0)
                       || (({1'b0, cmd_reg.start} < slot_end)
                           && ({1'b0, slot_start} < cmd_reg.range_end)));

    assign pend_live  = pend_vld_reg && valid_reg[pend_idx_reg];
    assign pend_other = (slot_owner != who_reg);
    assign conflict   = is_lock && pend_live && pend_other && clash;
    assign last_check = pend_vld_reg && (pend_idx_reg == IDX_W'(SLOT_COUNT - 1));
    assign free_here  = pend_vld_reg && !valid_reg[pend_idx_reg];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid && (q_cmd.op != OP_NONE))
                begin
                    state_next = B_SCAN;
                end
            end
            B_SCAN:
            begin
                if (conflict)
                begin
                    state_next = B_IDLE;
                end
                else if (last_check)
                begin
                    if (is_lock && (free_found_reg || free_here))
                    begin
                        state_next = B_WRITE;
                    end
                    else
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            B_WRITE:
            begin
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        cmd_next        = cmd_reg;
        who_next        = who_reg;
        issue_next      = issue_reg;
        pend_vld_next   = pend_vld_reg;
        pend_idx_next   = pend_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = issue_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop           = 1'b1;
                    cmd_next        = q_cmd;
                    who_next        = q_owner;
                    issue_next      = '0;
                    pend_vld_next   = 1'b0;
                    free_found_next = 1'b0;
                    if (q_cmd.op == OP_NONE)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_DONE;
                    end
                end
            end
            B_SCAN:
            begin
                // Issue the next slot read while checking the one read last cycle
                if (issue_reg < CNT_W'(SLOT_COUNT))
                begin
                    rd_en         = 1'b1;
                    issue_next    = issue_reg + CNT_W'(1);
                    pend_vld_next = 1'b1;
                    pend_idx_next = issue_reg[IDX_W-1:0];
                end
                else
                begin
                    pend_vld_next = 1'b0;
                end
                if (is_release && pend_live && !pend_other)
                begin
                    valid_next[pend_idx_reg] = 1'b0;
                end
                if (is_lock && free_here && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = pend_idx_reg;
                end
                if (conflict)
                begin
                    done_next   = 1'b1;
                    status_next = ST_CONFLICT;
                end
                else if (last_check)
                begin
                    if (is_release)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_DONE;
                    end
                    else if (!free_found_reg && !free_here)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_NO_FREE;
                    end
                end
            end
            B_WRITE:
            begin
                wr_en                    = 1'b1;
                valid_next[free_idx_reg] = 1'b1;
                done_next                = 1'b1;
                status_next              = ST_DONE;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            issue_reg      <= '0;
            pend_vld_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            done_reg       <= 1'b0;
            status_reg     <= ST_DONE;
        end
        else
        begin
            state_reg      <= state_next;
            issue_reg      <= issue_next;
            pend_vld_reg   <= pend_vld_next;
            free_found_reg <= free_found_next;
            valid_reg      <= valid_next;
            done_reg       <= done_next;
            status_reg     <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        who_reg      <= who_next;
        pend_idx_reg <= pend_idx_next;
        free_idx_reg <= free_idx_next;
    end

    assign done   = done_reg;
    assign status = status_reg;

endmodule

@@ sv/brlt_checker.sv @@
// Port-level checks for the byte-range lock table, bound to the top level.
module brlt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [1:0] status
);

    // The queue fills only on an accepted item
    a_busy_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted item");

    // A full queue drains only once the engine has delivered a result
    a_drain_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("queue drained while the engine was still working");

    // Status changes only together with a result strobe
    a_status_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> $stable(status))
        else $error("status changed without a result");

endmodule

bind byte_range_lock_table brlt_checker u_brlt_checker (.*);
